// ===== src/carv_pkg.sv =====
package carv_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = VAL_W + GAIN_W + 1;
    localparam int RND_W    = PROD_W - 15;
    localparam int SUM_W    = VAL_W + 3;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_FEEDBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd1;

    localparam logic [GAIN_W-1:0] COMB_FB_RESET = 16'd45875;
    localparam logic [GAIN_W-1:0] WET_MIX_RESET = 16'd32768;

    // Allpass gain, 0.7 in Q0.16.
    localparam logic [GAIN_W-1:0] AP_GAIN = 16'd45875;

    // Internal value limits, Q8.15.
    localparam logic signed [SUM_W-1:0] VAL_MAX = 27'sd8388607;
    localparam logic signed [SUM_W-1:0] VAL_MIN = -27'sd8388608;

    // Result queue: must hold every item that can be in the pipeline at once.
    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    // What a delay line hands back, registered in the cycle after its read data arrives.
    typedef struct packed {
        logic signed [VAL_W-1:0]  d;
        logic signed [PROD_W-1:0] prod;
    } t_line_out;

    // Clamp a widened value to the internal 24-bit range.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > VAL_MAX) begin
            r = VAL_MAX[VAL_W-1:0];
        end else if (v < VAL_MIN) begin
            r = VAL_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] add_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(a) + SUM_W'(b);
        return sat_val(t);
    endfunction

    function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(a) - SUM_W'(b);
        return sat_val(t);
    endfunction

    // Round a gain product to nearest, ties upward: floor((p + 2^15) / 2^16).
    function automatic logic signed [RND_W-1:0] gain_round(input logic signed [PROD_W-1:0] p);
        logic signed [RND_W-1:0] q;
        q = RND_W'(p >>> 16);
        return q + $signed({{(RND_W-1){1'b0}}, p[15]});
    endfunction

    // Saturating add of a value and a rounded gain product.
    function automatic logic signed [VAL_W-1:0] mac_add(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [RND_W-1:0] r);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(a) + SUM_W'(r);
        return sat_val(t);
    endfunction

endpackage

// ===== src/carv_in_if.sv =====
interface carv_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [carv_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/carv_out_if.sv =====
interface carv_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [carv_pkg::SAMPLE_W-1:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/carv_ram.sv =====
module carv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/carv_line.sv =====
module carv_line #(
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd,
    input  logic [carv_pkg::GAIN_W-1:0]            i_gain,
    input  logic signed [carv_pkg::VAL_W-1:0]      i_wdata,
    output carv_pkg::t_line_out                    o_line
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic          r_full;
    logic          r_v1;
    logic          r_v2;
    logic [AW-1:0] r_wa1;
    logic [AW-1:0] r_wa2;
    logic          r_zero;
    logic          r_byp;
    logic signed [carv_pkg::VAL_W-1:0] r_byp_data;
    logic [carv_pkg::VAL_W-1:0]        w_q;
    logic signed [carv_pkg::VAL_W-1:0] w_d;
    carv_pkg::t_line_out               r_line;

    // The position walks the line once per transfer and wraps at its length.
    assign n_pos = (r_pos == AW'(DEPTH - 1)) ? '0 : r_pos + AW'(1);

    // Position, fill flag and read/write tracking. The line has been fully
    // written once the position first wraps; before that every read is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= i_rd;
            r_v2 <= r_v1;
            if (i_rd) begin
                r_pos <= n_pos;
                if (r_pos == AW'(DEPTH - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    // The write address is the read position carried through r_wa1 and r_wa2. When a read hits the
    // entry that is written in the same cycle, the new value is forwarded.
    always_ff @(posedge i_clk) begin
        r_wa1 <= r_pos;
        r_wa2 <= r_wa1;
        if (i_rd) begin
            r_zero     <= !r_full;
            r_byp      <= r_v2 && (r_wa2 == r_pos);
            r_byp_data <= i_wdata;
        end
    end

    carv_ram #(
        .WIDTH (carv_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2),
        .i_waddr (r_wa2),
        .i_wdata (i_wdata),
        .i_re    (i_rd),
        .i_raddr (r_pos),
        .o_rdata (w_q)
    );

    // Tap value as the line holds it for this transfer.
    always_comb begin
        if (r_byp) begin
            w_d = r_byp_data;
        end else if (r_zero) begin
            w_d = '0;
        end else begin
            w_d = $signed(w_q);
        end
    end

    // Register the tap and its gain product.
    always_ff @(posedge i_clk) begin
        r_line.d    <= w_d;
        r_line.prod <= w_d * $signed({1'b0, i_gain});
    end

    assign o_line = r_line;

endmodule

// ===== src/carv_ofifo.sv =====
module carv_ofifo (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_reserve,
    input  logic                                  i_push,
    input  logic signed [carv_pkg::SAMPLE_W-1:0]  i_data,
    input  logic                                  i_pop,
    output logic                                  o_room,
    output logic                                  o_valid,
    output logic signed [carv_pkg::SAMPLE_W-1:0]  o_data
);

    logic signed [carv_pkg::SAMPLE_W-1:0] r_mem [carv_pkg::OFIFO_DEPTH];
    logic [carv_pkg::OFIFO_AW-1:0] r_wp;
    logic [carv_pkg::OFIFO_AW-1:0] r_rp;
    logic [carv_pkg::OFIFO_CW-1:0] r_cnt;
    logic [carv_pkg::OFIFO_CW-1:0] r_credit;

    // Credits count items accepted but not yet delivered, so a slot is
    // always free by the time an item leaves the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + carv_pkg::OFIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + carv_pkg::OFIFO_AW'(1);
            end
            r_cnt    <= r_cnt + carv_pkg::OFIFO_CW'(i_push) - carv_pkg::OFIFO_CW'(i_pop);
            r_credit <= r_credit + carv_pkg::OFIFO_CW'(i_reserve)
                        - carv_pkg::OFIFO_CW'(i_pop);
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_room  = r_credit < carv_pkg::OFIFO_CW'(carv_pkg::OFIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

endmodule

// ===== src/comb_allpass_reverb_core.sv =====
// Each accepted sample passes stages r_v[1] to r_v[7] into the result queue.
// Throughput: one sample per cycle while a queue credit is free; the pipeline
// advances every cycle and the 16-entry credited queue absorbs back-pressure.
// Reset (synchronous, active low) clears control state and restores the
// register defaults; each delay line reads as zero until its position has
// wrapped once, so no clearing pass is needed and samples are taken at once.
module comb_allpass_reverb_core #(
    parameter int COMB_A_LEN    = 1309,
    parameter int COMB_B_LEN    = 1636,
    parameter int COMB_C_LEN    = 1812,
    parameter int COMB_D_LEN    = 1927,
    parameter int ALLPASS_A_LEN = 220,
    parameter int ALLPASS_B_LEN = 74
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    carv_in_if.sink                            i_in,
    carv_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [carv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [carv_pkg::GAIN_W-1:0]        i_cfg_data
);

    localparam int VW = carv_pkg::VAL_W;
    localparam int SW = carv_pkg::SAMPLE_W;
    localparam int PX_W  = SW + 18;
    localparam int ACC_W = carv_pkg::PROD_W + 1;

    logic [carv_pkg::GAIN_W-1:0] r_comb_fb;
    logic [carv_pkg::GAIN_W-1:0] r_wet_mix;

    logic w_accept;
    logic w_room;
    logic w_pop;
    logic [7:1] r_v;
    logic signed [SW-1:0] r_x [1:6];

    carv_pkg::t_line_out w_comb [4];
    carv_pkg::t_line_out w_apa;
    carv_pkg::t_line_out w_apb;
    logic signed [VW-1:0] w_comb_wr [4];
    logic signed [VW-1:0] w_apa_wr;
    logic signed [VW-1:0] w_apb_wr;
    logic signed [VW-1:0] w_x2;

    logic signed [VW-1:0] r_sabc3;
    logic signed [VW-1:0] r_dd3;
    logic signed [VW-1:0] r_s4;
    logic signed [VW-1:0] r_ya5;
    logic signed [VW-1:0] r_yb6;
    logic signed [PX_W-1:0] r_px7;
    logic signed [carv_pkg::PROD_W-1:0] r_py7;
    logic [carv_pkg::GAIN_W:0] w_dry;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_accq;
    logic signed [SW-1:0] w_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_fb <= carv_pkg::COMB_FB_RESET;
            r_wet_mix <= carv_pkg::WET_MIX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                carv_pkg::REG_COMB_FEEDBACK: r_comb_fb <= i_cfg_data;
                carv_pkg::REG_WET_MIX:       r_wet_mix <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: accept while the result queue has a free credit.
    assign w_accept   = i_in.valid && w_room;
    assign i_in.ready = w_room;
    assign w_pop      = o_out.valid && o_out.ready;

    // Stage valid bits and the dry sample carried down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[1] <= i_in.sample_in;
        for (int k = 2; k <= 6; k++) begin
            r_x[k] <= r_x[k-1];
        end
    end

    assign w_x2 = VW'(r_x[2]);

    // Comb lines: read on transfer; once the tap leaves the line's output register, write back x + feedback.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_comb_wr[k] = carv_pkg::mac_add(w_x2, carv_pkg::gain_round(w_comb[k].prod));
        end
    end

    carv_line #(.DEPTH(COMB_A_LEN)) u_comb_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (w_accept),
        .i_gain (r_comb_fb), .i_wdata (w_comb_wr[0]), .o_line (w_comb[0])
    );
    carv_line #(.DEPTH(COMB_B_LEN)) u_comb_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (w_accept),
        .i_gain (r_comb_fb), .i_wdata (w_comb_wr[1]), .o_line (w_comb[1])
    );
    carv_line #(.DEPTH(COMB_C_LEN)) u_comb_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (w_accept),
        .i_gain (r_comb_fb), .i_wdata (w_comb_wr[2]), .o_line (w_comb[2])
    );
    carv_line #(.DEPTH(COMB_D_LEN)) u_comb_d (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (w_accept),
        .i_gain (r_comb_fb), .i_wdata (w_comb_wr[3]), .o_line (w_comb[3])
    );

    // Comb sum, saturating in line order.
    always_ff @(posedge i_clk) begin
        r_sabc3 <= carv_pkg::add_sat(carv_pkg::add_sat(w_comb[0].d, w_comb[1].d),
                                     w_comb[2].d);
        r_dd3   <= w_comb[3].d;
        r_s4    <= carv_pkg::add_sat(r_sabc3, r_dd3);
    end

    // First allpass: its read is timed so the tap arrives with the comb sum.
    assign w_apa_wr = carv_pkg::mac_add(r_s4, carv_pkg::gain_round(w_apa.prod));

    carv_line #(.DEPTH(ALLPASS_A_LEN)) u_ap_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (r_v[2]),
        .i_gain (carv_pkg::AP_GAIN), .i_wdata (w_apa_wr), .o_line (w_apa)
    );

    always_ff @(posedge i_clk) begin
        r_ya5 <= carv_pkg::sub_sat(w_apa.d, r_s4);
    end

    // Second allpass, read in the cycle after the first.
    assign w_apb_wr = carv_pkg::mac_add(r_ya5, carv_pkg::gain_round(w_apb.prod));

    carv_line #(.DEPTH(ALLPASS_B_LEN)) u_ap_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_rd (r_v[3]),
        .i_gain (carv_pkg::AP_GAIN), .i_wdata (w_apb_wr), .o_line (w_apb)
    );

    always_ff @(posedge i_clk) begin
        r_yb6 <= carv_pkg::sub_sat(w_apb.d, r_ya5);
    end

    // Dry/wet blend products.
    assign w_dry = 17'd65536 - {1'b0, r_wet_mix};

    always_ff @(posedge i_clk) begin
        r_px7 <= r_x[6] * $signed({1'b0, w_dry});
        r_py7 <= r_yb6 * $signed({1'b0, r_wet_mix});
    end

    // Sum, round to nearest and clamp to the output range.
    always_comb begin
        w_acc  = ACC_W'(r_px7) + ACC_W'(r_py7) + ACC_W'(32768);
        w_accq = w_acc >>> 16;
        if (w_accq > ACC_W'(32767)) begin
            w_out = 16'sh7FFF;
        end else if (w_accq < -ACC_W'(32768)) begin
            w_out = 16'sh8000;
        end else begin
            w_out = w_accq[SW-1:0];
        end
    end

    carv_ofifo u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (w_accept),
        .i_push    (r_v[7]),
        .i_data    (w_out),
        .i_pop     (w_pop),
        .o_room    (w_room),
        .o_valid   (o_out.valid),
        .o_data    (o_out.sample_out)
    );

endmodule

// ===== verif/tb_comb_allpass_reverb_core.sv =====
`timescale 1ns / 1ps

module tb_comb_allpass_reverb_core;
    import carv_pkg::*;

    localparam int COMB_A_LEN    = 1309;
    localparam int COMB_B_LEN    = 1636;
    localparam int COMB_C_LEN    = 1812;
    localparam int COMB_D_LEN    = 1927;
    localparam int ALLPASS_A_LEN = 220;
    localparam int ALLPASS_B_LEN = 74;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int  PHASE_ITEMS = 325;
    localparam int  SETTLE_CYCLES = 16;
    localparam longint CYCLE_LIMIT = 400000;

    typedef bit signed [VAL_W-1:0]    t_val;
    typedef bit signed [SAMPLE_W-1:0] t_smp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;

    carv_in_if  dry_bus ();
    carv_out_if mix_bus ();

    comb_allpass_reverb_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (dry_bus),
        .o_out      (mix_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: delay lines, their positions and the gain registers.
    t_val comb_mem [4][2048];
    t_val ap_mem   [2][256];
    int   comb_len [4] = '{COMB_A_LEN, COMB_B_LEN, COMB_C_LEN, COMB_D_LEN};
    int   ap_len   [2] = '{ALLPASS_A_LEN, ALLPASS_B_LEN};
    int   comb_pos [4] = '{0, 0, 0, 0};
    int   ap_pos   [2] = '{0, 0};
    bit [GAIN_W-1:0] fb_gain  = COMB_FB_RESET;
    bit [GAIN_W-1:0] wet_gain = WET_MIX_RESET;

    t_smp   dry_samples_q[$];
    t_smp   reverb_out_q[$];
    int     queued_cnt   = 0;
    int     accepted_cnt = 0;
    int     err_cnt      = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    longint cycle_cnt = 0;

    function automatic t_val clamp24(input longint v);
        t_val r;
        if (v > 64'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = t_val'(v);
        end
        return r;
    endfunction

    // Gain product rounded to nearest with ties upward.
    function automatic longint scale_gain(input t_val v, input bit [GAIN_W-1:0] g);
        return (longint'(v) * longint'(g) + 64'sd32768) >>> 16;
    endfunction

    // Advances the reverb state by one dry sample and returns the mixed output.
    function automatic t_smp reverb_predict(input t_smp dry);
        longint x;
        longint sum;
        longint acc;
        t_val   d;
        t_val   y;
        int     p;
        x   = dry;
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            p = comb_pos[k];
            d = comb_mem[k][p];
            comb_mem[k][p] = clamp24(x + scale_gain(d, fb_gain));
            comb_pos[k] = (p + 1 >= comb_len[k]) ? 0 : p + 1;
            sum = clamp24(sum + d);
        end
        for (int k = 0; k < 2; k++) begin
            p = ap_pos[k];
            d = ap_mem[k][p];
            y = clamp24(longint'(d) - sum);
            ap_mem[k][p] = clamp24(sum + scale_gain(d, AP_GAIN));
            ap_pos[k] = (p + 1 >= ap_len[k]) ? 0 : p + 1;
            sum = y;
        end
        acc = (x * (64'sd65536 - longint'(wet_gain)) + sum * longint'(wet_gain)
               + 64'sd32768) >>> 16;
        if (acc > 64'sd32767) begin
            acc = 32767;
        end else if (acc < -64'sd32768) begin
            acc = -32768;
        end
        return t_smp'(acc);
    endfunction

    // Mix of full-scale, quiet and arbitrary samples.
    function automatic t_smp pick_dry(input int loud_pct);
        t_smp r;
        if ($urandom_range(99) < loud_pct) begin
            case ($urandom_range(3))
                0: r = 16'sh7fff;
                1: r = 16'sh8000;
                2: r = t_smp'(16'sh7fff - $urandom_range(255));
                default: r = t_smp'(16'sh8000 + $urandom_range(255));
            endcase
        end else if ($urandom_range(3) == 0) begin
            r = t_smp'($urandom_range(511)) - 16'sd256;
        end else begin
            r = t_smp'($urandom);
        end
        return r;
    endfunction

    // Driver: offers queued samples and runs the predictor on each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dry_bus.valid     <= 1'b0;
            dry_bus.sample_in <= '0;
        end else begin
            if (dry_bus.valid && dry_bus.ready) begin
                reverb_out_q.insert(reverb_out_q.size(), reverb_predict(dry_bus.sample_in));
                accepted_cnt++;
            end
            if (!dry_bus.valid || dry_bus.ready) begin
                if (dry_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    dry_bus.valid     <= 1'b1;
                    dry_bus.sample_in <= dry_samples_q.pop_front();
                end else begin
                    dry_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mix_bus.ready <= 1'b0;
        end else begin
            if (mix_bus.valid && mix_bus.ready) begin
                if (reverb_out_q.size() == 0) begin
                    $error("sample_out: unexpected transfer, actual %0d", mix_bus.sample_out);
                    err_cnt++;
                end else begin
                    t_smp want;
                    want = reverb_out_q.pop_front();
                    if (mix_bus.sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want, mix_bus.sample_out);
                        err_cnt++;
                    end
                end
            end
            mix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Registers only change here, with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_COMB_FEEDBACK: fb_gain = val;
            REG_WET_MIX:       wet_gain = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || reverb_out_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_dry(input t_smp s);
        dry_samples_q.insert(dry_samples_q.size(), s);
        queued_cnt++;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int loud_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_dry(pick_dry(loud_pct));
        end
        wait_drained();
    endtask

    initial begin
        t_smp directed [20] = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                                16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                16'sh8000, 16'sh8000, 16'sh8000, 16'sh4000, -16'sh4000,
                                16'sh0001, 16'sh8001, 16'sh7ffe, 16'sh00ff, 16'shff00};
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes and bit patterns at the reset gains.
        foreach (directed[i]) begin
            push_dry(directed[i]);
        end
        wait_drained();

        // Gain extremes at full rate.
        write_reg(REG_COMB_FEEDBACK, 16'hffff);
        write_reg(REG_WET_MIX, 16'hffff);
        run_phase(0, 0, 25);

        // Dry only, no feedback, with a slow sender.
        write_reg(REG_COMB_FEEDBACK, 16'h0000);
        write_reg(REG_WET_MIX, 16'h0000);
        run_phase(52, 0, 25);

        // Default feedback, all wet, with a slow receiver.
        write_reg(REG_COMB_FEEDBACK, COMB_FB_RESET);
        write_reg(REG_WET_MIX, 16'hffff);
        run_phase(0, 52, 25);

        write_reg(REG_COMB_FEEDBACK, 16'($urandom_range(65535)));
        write_reg(REG_WET_MIX, 16'($urandom_range(65535)));
        run_phase(38, 38, 25);

        // Feedback near one with loud input drives the lines toward their limits.
        write_reg(REG_COMB_FEEDBACK, 16'hffff);
        write_reg(REG_WET_MIX, WET_MIX_RESET);
        run_phase(0, 0, 70);

        // Writes past the register list must leave the gains alone.
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
        write_reg(REG_COMB_FEEDBACK, 16'($urandom_range(65535)));
        write_reg(REG_SPARE_2, 16'($urandom));
        run_phase(38, 38, 40);

        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && reverb_out_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
